// ===== hw/rtl/tccs_pkg.sv =====
package tccs_pkg;

  // command codes
  localparam logic [1:0] MODE_PRINT = 2'd0;
  localparam logic [1:0] MODE_BACKSPACE = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;
  localparam logic [1:0] MODE_SET_CURSOR = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_DRAW = 2'd0;
  localparam logic [1:0] KIND_SCROLL = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;
  localparam logic [1:0] KIND_REPORT = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_COLUMNS = 2'd0;
  localparam logic [1:0] REG_ROWS = 2'd1;
  localparam logic [1:0] REG_PROTECTED_ROW = 2'd2;

  localparam logic [7:0] CHAR_NEWLINE = 8'd10;
  localparam logic [7:0] CHAR_SPACE = 8'd32;

  localparam logic [7:0] COLUMNS_RESET = 8'd80;
  localparam logic [6:0] ROWS_RESET = 7'd25;

  // restoring divider: one quotient bit per cycle over the cell index
  localparam int DIV_STEPS = 15;
  localparam int COUNT_W = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  character;
    logic [14:0] target_cell;
  } cmd_word_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] glyph;
    logic [7:0] cell_col;
    logic [6:0] cell_row;
    logic [7:0] cursor_col_out;
    logic [6:0] cursor_row_out;
    logic       last;
  } res_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_COMMIT,
    ST_SEND_FIRST,
    ST_SEND_LAST
  } state_t;

  typedef struct packed {
    logic capture;
    logic div_step;
    logic div_commit;
    logic load_first;
    logic load_last;
  } ctrl_t;

  typedef struct packed {
    logic div_cmd;
    logic two_results;
    logic out_free;
  } stat_t;

endpackage

// ===== hw/rtl/tccs_ctrl.sv =====
module tccs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_stall,
  input  tccs_pkg::stat_t stat,
  output tccs_pkg::ctrl_t ctrl
);

  tccs_pkg::state_t state;
  tccs_pkg::state_t state_next;
  logic [tccs_pkg::COUNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tccs_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (state == tccs_pkg::ST_DIVIDE) begin
        count <= count + 1'b1;
      end else begin
        count <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tccs_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          state_next = stat.div_cmd ? tccs_pkg::ST_DIVIDE : tccs_pkg::ST_SEND_FIRST;
        end
      end
      tccs_pkg::ST_DIVIDE: begin
        if (count == tccs_pkg::COUNT_W'(tccs_pkg::DIV_STEPS - 1)) begin
          state_next = tccs_pkg::ST_COMMIT;
        end
      end
      tccs_pkg::ST_COMMIT: begin
        state_next = tccs_pkg::ST_SEND_FIRST;
      end
      tccs_pkg::ST_SEND_FIRST: begin
        if (stat.out_free) begin
          state_next = stat.two_results ? tccs_pkg::ST_SEND_LAST : tccs_pkg::ST_IDLE;
        end
      end
      tccs_pkg::ST_SEND_LAST: begin
        if (stat.out_free) begin
          state_next = tccs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tccs_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_stall = (state != tccs_pkg::ST_IDLE);
    ctrl.capture = (state == tccs_pkg::ST_IDLE) && cmd_valid;
    ctrl.div_step = (state == tccs_pkg::ST_DIVIDE);
    ctrl.div_commit = (state == tccs_pkg::ST_COMMIT);
    ctrl.load_first = (state == tccs_pkg::ST_SEND_FIRST) && stat.out_free;
    ctrl.load_last = (state == tccs_pkg::ST_SEND_LAST) && stat.out_free;
  end

endmodule

// ===== hw/rtl/tccs_dpath.sv =====
module tccs_dpath (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [7:0]            cfg_data,
  input  tccs_pkg::cmd_word_t   cmd_word,
  output logic                  res_valid,
  input  logic                  res_stall,
  output tccs_pkg::res_word_t   res_word,
  input  tccs_pkg::ctrl_t       ctrl,
  output tccs_pkg::stat_t       stat
);

  // configuration
  logic [7:0] columns;
  logic [6:0] rows;
  logic [6:0] protected_row;

  // cursor
  logic [7:0] column_now;
  logic [6:0] row_now;

  // divider
  logic [14:0] dvd;
  logic [7:0]  rem;

  // pending results
  logic [1:0] res_kind;
  logic [7:0] res_glyph;
  logic [7:0] res_col;
  logic [6:0] res_row;
  logic       two;

  // effective grid
  logic [7:0] ncol;
  logic [6:0] nrow;
  logic [6:0] bottom_row;
  logic [6:0] prow;
  logic [7:0] col0;
  logic [6:0] row_lo;
  logic [6:0] row0;

  // per-command work
  logic [7:0] col_inc;
  logic       wrap;
  logic [7:0] row_inc;
  logic       scroll;
  logic [7:0] col_new;
  logic [6:0] row_new;
  logic [1:0] kind_new;
  logic [7:0] glyph_new;
  logic [7:0] ccol_new;
  logic [6:0] crow_new;
  logic       two_new;

  // divider step and final clamp
  logic [8:0] rem_sh;
  logic       qbit;
  logic [6:0] row_div;

  always_comb begin
    ncol = (columns == 8'd0) ? 8'd1 : columns;
    nrow = (rows == 7'd0) ? 7'd1 : rows;
    bottom_row = nrow - 7'd1;
    prow = (protected_row < nrow) ? protected_row : bottom_row;
    col0 = (column_now >= ncol) ? ncol - 8'd1 : column_now;
    row_lo = (row_now < prow) ? prow : row_now;
    row0 = (row_lo >= nrow) ? bottom_row : row_lo;
  end

  always_comb begin
    col_inc = col0 + 8'd1;
    wrap = (col_inc >= ncol);
    if (cmd_word.character == tccs_pkg::CHAR_NEWLINE) begin
      row_inc = {1'b0, row0} + 8'd1;
    end else begin
      row_inc = {1'b0, row0} + {7'd0, wrap};
    end
    scroll = (row_inc >= {1'b0, nrow});

    col_new = col0;
    row_new = row0;
    kind_new = tccs_pkg::KIND_REPORT;
    glyph_new = 8'd0;
    ccol_new = 8'd0;
    crow_new = 7'd0;
    two_new = 1'b0;
    case (cmd_word.mode)
      tccs_pkg::MODE_PRINT: begin
        row_new = scroll ? bottom_row : row_inc[6:0];
        if (cmd_word.character == tccs_pkg::CHAR_NEWLINE) begin
          col_new = 8'd0;
          if (scroll) begin
            kind_new = tccs_pkg::KIND_SCROLL;
            crow_new = prow;
          end
        end else begin
          col_new = wrap ? 8'd0 : col_inc;
          kind_new = tccs_pkg::KIND_DRAW;
          glyph_new = cmd_word.character;
          ccol_new = col0;
          crow_new = row0;
          two_new = scroll;
        end
      end
      tccs_pkg::MODE_BACKSPACE: begin
        if (col0 != 8'd0) begin
          col_new = col0 - 8'd1;
        end else if (row0 > prow) begin
          row_new = row0 - 7'd1;
          col_new = ncol - 8'd1;
        end
        kind_new = tccs_pkg::KIND_DRAW;
        glyph_new = tccs_pkg::CHAR_SPACE;
        ccol_new = col_new;
        crow_new = row_new;
      end
      tccs_pkg::MODE_CLEAR: begin
        col_new = 8'd0;
        row_new = prow;
        kind_new = tccs_pkg::KIND_CLEAR;
        crow_new = prow;
      end
      default: begin
        // set cursor is finished by the divider
      end
    endcase
  end

  always_comb begin
    rem_sh = {rem, dvd[14]};
    qbit = (rem_sh >= {1'b0, ncol});
    if (dvd < {8'd0, prow}) begin
      row_div = prow;
    end else if (dvd >= {8'd0, nrow}) begin
      row_div = bottom_row;
    end else begin
      row_div = dvd[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      columns <= tccs_pkg::COLUMNS_RESET;
      rows <= tccs_pkg::ROWS_RESET;
      protected_row <= 7'd0;
      column_now <= 8'd0;
      row_now <= 7'd0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tccs_pkg::REG_COLUMNS: columns <= cfg_data;
          tccs_pkg::REG_ROWS: rows <= cfg_data[6:0];
          tccs_pkg::REG_PROTECTED_ROW: protected_row <= cfg_data[6:0];
          default: begin
          end
        endcase
      end
      if (ctrl.capture && cmd_word.mode != tccs_pkg::MODE_SET_CURSOR) begin
        column_now <= col_new;
        row_now <= row_new;
      end else if (ctrl.div_commit) begin
        column_now <= rem;
        row_now <= row_div;
      end
      if (ctrl.load_first || ctrl.load_last) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      dvd <= cmd_word.target_cell;
      rem <= 8'd0;
      res_kind <= kind_new;
      res_glyph <= glyph_new;
      res_col <= ccol_new;
      res_row <= crow_new;
      two <= two_new;
    end else if (ctrl.div_step) begin
      rem <= qbit ? 8'(rem_sh - {1'b0, ncol}) : rem_sh[7:0];
      dvd <= {dvd[13:0], qbit};
    end else if (ctrl.div_commit) begin
      res_kind <= tccs_pkg::KIND_REPORT;
      res_glyph <= 8'd0;
      res_col <= 8'd0;
      res_row <= 7'd0;
      two <= 1'b0;
    end
    if (ctrl.load_first) begin
      res_word.kind <= res_kind;
      res_word.glyph <= res_glyph;
      res_word.cell_col <= res_col;
      res_word.cell_row <= res_row;
      res_word.cursor_col_out <= column_now;
      res_word.cursor_row_out <= row_now;
      res_word.last <= !two;
    end else if (ctrl.load_last) begin
      res_word.kind <= tccs_pkg::KIND_SCROLL;
      res_word.glyph <= 8'd0;
      res_word.cell_col <= 8'd0;
      res_word.cell_row <= prow;
      res_word.last <= 1'b1;
    end
  end

  always_comb begin
    stat.div_cmd = (cmd_word.mode == tccs_pkg::MODE_SET_CURSOR);
    stat.two_results = two;
    stat.out_free = !res_valid || !res_stall;
  end

endmodule

// ===== hw/rtl/text_console_cursor_scroll_core.sv =====
// channel   dir  handshake              word
// cmd       in   cmd_valid / cmd_stall  cmd_word: mode, character, target_cell
// res       out  res_valid / res_stall  res_word: kind, glyph, cell, cursor, last
// cfg       in   cfg_we                 cfg_index, cfg_data (no read-back)
//
// print, backspace and clear go from capture straight to sending, a second send when a glyph scrolls
// set cursor runs the 15-step restoring divider (one bit a cycle), then commits the cursor
// synchronous active-high reset: cursor to 0,0, registers to 80 x 25, protected row 0
// cmd_stall is high from acceptance until the last result enters the output register
// a stalled result sits in the output register while the next command is taken
module text_console_cursor_scroll_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  tccs_pkg::cmd_word_t cmd_word,
  output logic                res_valid,
  input  logic                res_stall,
  output tccs_pkg::res_word_t res_word
);

  // command and status between sequencer and datapath
  tccs_pkg::ctrl_t ctrl;
  tccs_pkg::stat_t stat;

  // sequencer: capture, divide and commit for set cursor, then one or two sends
  tccs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  // datapath: registers, cursor, divider, pending results and output register
  tccs_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_word  (cmd_word),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word),
    .ctrl      (ctrl),
    .stat      (stat)
  );

  // a taken command keeps the input side closed on the following cycle
  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |=> cmd_stall
  ) else $error("command taken while previous one still in progress");

  // the second result of a command follows the first without a gap
  a_last_follows: assert property (
    @(posedge clk) disable iff (rst)
    (res_valid && !res_stall && !res_word.last) |=> (res_valid && res_word.last)
  ) else $error("second result missing after first");

  // only a drawn glyph is ever followed by a further result
  a_first_is_draw: assert property (
    @(posedge clk) disable iff (rst)
    (res_valid && !res_word.last) |-> (res_word.kind == tccs_pkg::KIND_DRAW)
  ) else $error("non-final result is not a glyph draw");

endmodule

// ===== sim/text_console_cursor_scroll_core_tb.sv =====
module text_console_cursor_scroll_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_PHASES = 8;
  localparam int WORDS_PER_PHASE = 105;
  localparam int HOLD_CYCLES = 80;
  localparam int QUIET_LIMIT = 4000;
  localparam int SCRIPT_ROWS = 17;
  localparam int TAIL_CYCLES = 40;

  // one row of the directed script: typed rows carry their own expected word
  typedef struct packed {
    logic                typed;
    tccs_pkg::cmd_word_t cmd;
    tccs_pkg::res_word_t res;
  } script_row_t;

  localparam tccs_pkg::res_word_t NO_RES = '0;

  // directed script, run at the reset grid of 80 x 25 with no protected rows
  localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
    // clear straight after reset homes to 0,0
    {1'b1, {tccs_pkg::MODE_CLEAR, 8'h00, 15'd0},
     {tccs_pkg::KIND_CLEAR, 8'd0, 8'd0, 7'd0, 8'd0, 7'd0, 1'b1}},
    // backspace at the start of the protected row: space drawn, cursor stays
    {1'b1, {tccs_pkg::MODE_BACKSPACE, 8'h00, 15'd0},
     {tccs_pkg::KIND_DRAW, tccs_pkg::CHAR_SPACE, 8'd0, 7'd0, 8'd0, 7'd0, 1'b1}},
    {1'b0, {tccs_pkg::MODE_PRINT, 8'h41, 15'd0}, NO_RES},
    {1'b0, {tccs_pkg::MODE_PRINT, 8'hFF, 15'h7FFF}, NO_RES},
    {1'b0, {tccs_pkg::MODE_PRINT, 8'h00, 15'd0}, NO_RES},
    {1'b0, {tccs_pkg::MODE_PRINT, tccs_pkg::CHAR_NEWLINE, 15'd0}, NO_RES},
    // largest cell index: row clamped to the last row, column 32767 mod 80
    {1'b1, {tccs_pkg::MODE_SET_CURSOR, 8'h00, 15'h7FFF},
     {tccs_pkg::KIND_REPORT, 8'd0, 8'd0, 7'd0, 8'd47, 7'd24, 1'b1}},
    {1'b0, {tccs_pkg::MODE_PRINT, 8'h7E, 15'd0}, NO_RES},
    // bottom right cell of the grid
    {1'b1, {tccs_pkg::MODE_SET_CURSOR, 8'h00, 15'd1999},
     {tccs_pkg::KIND_REPORT, 8'd0, 8'd0, 7'd0, 8'd79, 7'd24, 1'b1}},
    // wrap off the last cell: draw then scroll
    {1'b0, {tccs_pkg::MODE_PRINT, 8'h5A, 15'd0}, NO_RES},
    // newline on the last row scrolls
    {1'b0, {tccs_pkg::MODE_PRINT, tccs_pkg::CHAR_NEWLINE, 15'd0}, NO_RES},
    // backspace at column 0 goes back to the previous row
    {1'b0, {tccs_pkg::MODE_BACKSPACE, 8'h00, 15'd0}, NO_RES},
    {1'b1, {tccs_pkg::MODE_SET_CURSOR, 8'h00, 15'd0},
     {tccs_pkg::KIND_REPORT, 8'd0, 8'd0, 7'd0, 8'd0, 7'd0, 1'b1}},
    {1'b0, {tccs_pkg::MODE_SET_CURSOR, 8'h00, 15'h5555}, NO_RES},
    {1'b0, {tccs_pkg::MODE_SET_CURSOR, 8'h00, 15'h2AAA}, NO_RES},
    {1'b0, {tccs_pkg::MODE_BACKSPACE, 8'h00, 15'd0}, NO_RES},
    {1'b0, {tccs_pkg::MODE_PRINT, tccs_pkg::CHAR_SPACE, 15'd0}, NO_RES}
  };

  // register settings of the random phases: reset grid, zero sizes, largest,
  // smallest, protected row past the grid, one row, one column, a small grid
  localparam logic [7:0] PHASE_COLUMNS [NUM_PHASES] =
    '{8'd80, 8'd0, 8'd255, 8'd1, 8'd7, 8'd255, 8'd1, 8'd12};
  localparam logic [6:0] PHASE_ROWS [NUM_PHASES] =
    '{7'd25, 7'd0, 7'd127, 7'd1, 7'd5, 7'd1, 7'd127, 7'd6};
  localparam logic [6:0] PHASE_PROT [NUM_PHASES] =
    '{7'd0, 7'd0, 7'd126, 7'd0, 7'd9, 7'd0, 7'd126, 7'd2};

  logic      clk;
  logic      rst;
  logic      cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;
  logic      cmd_valid;
  logic      cmd_stall;
  tccs_pkg::cmd_word_t cmd_word;
  logic      res_valid;
  logic      res_stall;
  tccs_pkg::res_word_t res_word;

  text_console_cursor_scroll_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_word  (cmd_word),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
  );

  // shadow registers and cursor kept by the console model
  logic [7:0] grid_columns;
  logic [6:0] grid_rows;
  logic [6:0] grid_prot_row;
  logic [7:0] cur_col;
  logic [6:0] cur_row;

  // words produced by the last command, and the words still owed by the block
  tccs_pkg::res_word_t step_words [2];
  int                  step_count;
  tccs_pkg::res_word_t owed_words [$];

  int fail_count = 0;
  int cmd_count = 0;
  int word_count = 0;
  int scroll_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_asked = 0;
  int hold_done;
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // console model
  function automatic void add_word(input logic [1:0] kind, input logic [7:0] glyph,
                                   input int ccol, input int crow);
    step_words[step_count] = '{kind: kind, glyph: glyph, cell_col: ccol[7:0],
                               cell_row: crow[6:0], cursor_col_out: 8'd0,
                               cursor_row_out: 7'd0, last: 1'b0};
    step_count++;
  endfunction

  function automatic void console_step(input tccs_pkg::cmd_word_t w);
    int ncol;
    int nrow;
    int prow;
    int col;
    int row;

    // zero sizes count as one, protected row limited to the last row
    ncol = (grid_columns == 0) ? 1 : int'(grid_columns);
    nrow = (grid_rows == 0) ? 1 : int'(grid_rows);
    prow = (int'(grid_prot_row) < nrow) ? int'(grid_prot_row) : nrow - 1;
    col = int'(cur_col);
    row = int'(cur_row);
    step_count = 0;

    // pull a cursor left outside the grid by a register change back in
    if (col >= ncol) col = ncol - 1;
    if (row < prow) row = prow;
    if (row >= nrow) row = nrow - 1;

    case (w.mode)
      tccs_pkg::MODE_PRINT: begin
        if (w.character == tccs_pkg::CHAR_NEWLINE) begin
          col = 0;
          row++;
          if (row >= nrow) begin
            row = nrow - 1;
            add_word(tccs_pkg::KIND_SCROLL, 8'd0, 0, prow);
          end else begin
            add_word(tccs_pkg::KIND_REPORT, 8'd0, 0, 0);
          end
        end else begin
          add_word(tccs_pkg::KIND_DRAW, w.character, col, row);
          col++;
          if (col >= ncol) begin
            col = 0;
            row++;
          end
          if (row >= nrow) begin
            row = nrow - 1;
            add_word(tccs_pkg::KIND_SCROLL, 8'd0, 0, prow);
          end
        end
      end
      tccs_pkg::MODE_BACKSPACE: begin
        if (col > 0) begin
          col--;
        end else if (row > prow) begin
          row--;
          col = ncol - 1;
        end
        add_word(tccs_pkg::KIND_DRAW, tccs_pkg::CHAR_SPACE, col, row);
      end
      tccs_pkg::MODE_CLEAR: begin
        col = 0;
        row = prow;
        add_word(tccs_pkg::KIND_CLEAR, 8'd0, 0, prow);
      end
      tccs_pkg::MODE_SET_CURSOR: begin
        row = int'(w.target_cell) / ncol;
        col = int'(w.target_cell) % ncol;
        add_word(tccs_pkg::KIND_REPORT, 8'd0, 0, 0);
      end
      default: begin
      end
    endcase

    if (row < prow) row = prow;
    if (row >= nrow) row = nrow - 1;
    cur_col = col[7:0];
    cur_row = row[6:0];

    for (int i = 0; i < step_count; i++) begin
      step_words[i].cursor_col_out = cur_col;
      step_words[i].cursor_row_out = cur_row;
      step_words[i].last = (i == step_count - 1);
    end
  endfunction

  // random commands, mostly text with newlines, some editing and cursor moves
  function automatic tccs_pkg::cmd_word_t random_cmd();
    tccs_pkg::cmd_word_t w;
    int pick;
    int span;

    pick = $urandom_range(99);
    w.mode = tccs_pkg::MODE_PRINT;
    w.character = 8'($urandom_range(255));
    w.target_cell = 15'($urandom_range(32767));
    span = ((grid_columns == 0) ? 1 : int'(grid_columns)) *
           ((grid_rows == 0) ? 1 : int'(grid_rows));
    if (pick < 50) begin
      w.mode = tccs_pkg::MODE_PRINT;
    end else if (pick < 62) begin
      w.character = tccs_pkg::CHAR_NEWLINE;
    end else if (pick < 80) begin
      w.mode = tccs_pkg::MODE_BACKSPACE;
    end else if (pick < 85) begin
      w.mode = tccs_pkg::MODE_CLEAR;
    end else begin
      w.mode = tccs_pkg::MODE_SET_CURSOR;
      // mostly a cell on the grid, otherwise anywhere in the index range
      if (pick < 95) w.target_cell = 15'($urandom_range(span - 1));
    end
    return w;
  endfunction

  // offer one command word, wait for it to be taken, then book its results
  task automatic send_cmd(input tccs_pkg::cmd_word_t w, input logic typed,
                          input tccs_pkg::res_word_t typed_res);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_word <= w;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    cmd_count++;
    console_step(w);
    if (typed) begin
      owed_words.push_back(typed_res);
    end else begin
      for (int i = 0; i < step_count; i++) owed_words.push_back(step_words[i]);
    end
  endtask

  // sender pauses until the block has handed over every owed word
  task automatic drain();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (owed_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      tccs_pkg::REG_COLUMNS: grid_columns = value;
      tccs_pkg::REG_ROWS: grid_rows = value[6:0];
      tccs_pkg::REG_PROTECTED_ROW: grid_prot_row = value[6:0];
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // receiver: random stalls, plus a long hold-off when one is asked for
  initial begin
    int hold_left;
    hold_left = 0;
    hold_done = 0;
    res_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left == 0 && hold_asked != hold_done) begin
        hold_done++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // result checker: every taken word against the oldest owed one
  always @(posedge clk) begin
    tccs_pkg::res_word_t want;
    if (!rst && res_valid && !res_stall) begin
      if (owed_words.size() == 0) begin
        $error("result word %h arrived with none owed", res_word);
        fail_count++;
      end else begin
        want = owed_words.pop_front();
        check_field("kind", want.kind, res_word.kind);
        check_field("glyph", want.glyph, res_word.glyph);
        check_field("cell_col", want.cell_col, res_word.cell_col);
        check_field("cell_row", want.cell_row, res_word.cell_row);
        check_field("cursor_col_out", want.cursor_col_out, res_word.cursor_col_out);
        check_field("cursor_row_out", want.cursor_row_out, res_word.cursor_row_out);
        check_field("last", want.last, res_word.last);
        word_count++;
        if (want.kind == tccs_pkg::KIND_SCROLL) scroll_count++;
      end
    end
  end

  // watchdog: too long without either channel moving ends the run
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = tccs_pkg::REG_COLUMNS;
    cfg_data = 8'd0;
    cmd_valid = 1'b0;
    cmd_word = '0;
    grid_columns = tccs_pkg::COLUMNS_RESET;
    grid_rows = tccs_pkg::ROWS_RESET;
    grid_prot_row = 7'd0;
    cur_col = 8'd0;
    cur_row = 7'd0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed script at the reset grid, no idling
    for (int i = 0; i < SCRIPT_ROWS; i++) begin
      send_cmd(SCRIPT[i].cmd, SCRIPT[i].typed, SCRIPT[i].res);
    end
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      // block is idle here: reprogram the grid
      write_reg(tccs_pkg::REG_COLUMNS, PHASE_COLUMNS[p]);
      write_reg(tccs_pkg::REG_ROWS, {1'b0, PHASE_ROWS[p]});
      write_reg(tccs_pkg::REG_PROTECTED_ROW, {1'b0, PHASE_PROT[p]});
      @(negedge clk);
      cfg_we <= 1'b0;

      // rotate through the idling patterns
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 62; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 62; end
        default: begin idle_pct = 12; stall_pct = 12; end
      endcase

      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        // long receiver hold-off while the sender keeps offering
        if (p == 0 && k == 30) hold_asked++;
        send_cmd(random_cmd(), 1'b0, NO_RES);
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d command words over %0d grid settings and four idling patterns",
             cmd_count, NUM_PHASES + 1);
    $display("checked %0d result words, %0d of them scrolls, with one long receiver hold-off",
             word_count, scroll_count);
    if (fail_count == 0 && owed_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
